FILE: hw/rtl/crs_pkg.sv
package crs_pkg;

  // Coordinate format of the rope points and of the curve points.
  localparam int unsigned COORD_WIDTH = 32;

  // Width of the subdivision count register.
  localparam int unsigned SUB_W = 5;

  // Working width of the cubic coefficients and of the Horner accumulator.
  // Five guard bits cover the largest coefficient and every partial sum.
  localparam int unsigned COEF_W = COORD_WIDTH + 5;

  // Register port layout: 32-bit data, word addressed, one register.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned IDX_W  = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_SUBDIVISIONS = '0;
  localparam logic [SUB_W-1:0] SUBDIV_RESET     = SUB_W'(1);

  // One rope control point.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          final_point;
  } in_req_t;

  // One curve point.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic signed [COORD_WIDTH-1:0] curve_z;
    logic                          run_last;
    logic                          rope_end;
  } out_req_t;

  // One operation of the shared multiply-add unit.
  typedef struct packed {
    logic signed [COEF_W-1:0] acc;
    logic signed [COEF_W-1:0] addend;
    logic                     half;
  } mac_op_t;

endpackage

FILE: hw/rtl/catmull_rom_subdivider.sv
// Catmull-Rom rope subdivider with one shared multiply-add unit.
// Per request: the divider forms 2^F/S, then per segment the coefficients are loaded and per
// curve point come three Horner products and a store per coordinate and a hand-over of the
// point; the rope's end point is handed over last. Output stalls hold the hand-overs.
// A new request is stalled until the block is idle again. Reset: asynchronous, active low;
// subdivisions back to 1.
module catmull_rom_subdivider #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned MAX_SUBDIV = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  crs_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output crs_pkg::out_req_t          out_req_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crs_pkg::ADDR_W-1:0] paddr,
  input  logic [crs_pkg::DATA_W-1:0] pwdata,
  output logic [crs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned W     = crs_pkg::COORD_WIDTH;
  localparam int unsigned SubW  = crs_pkg::SUB_W;
  localparam int unsigned CoefW = crs_pkg::COEF_W;
  localparam logic [SubW-1:0] MaxSub = SubW'(MAX_SUBDIV);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_COEF  = 6'b000100,
    ST_MAC   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_FINAL = 6'b100000
  } state_e;

  // Which four points make up the current segment.
  typedef enum logic [1:0] {
    SEG_FULL,   // window 0,1,2 and the new point
    SEG_HEAD,   // first segment, first point doubled
    SEG_TAIL,   // last segment, end point doubled
    SEG_SHORT   // two-point rope
  } seg_e;

  typedef enum logic [1:0] {
    K_CUBIC,
    K_SQUARE,
    K_LINEAR,
    K_STORE
  } step_e;

  function automatic logic signed [CoefW-1:0] sext_c(input logic signed [W-1:0] v);
    return {{(CoefW-W){v[W-1]}}, v};
  endfunction

  state_e state_q, state_d;
  seg_e   segk_q, segk_d;
  step_e  k_q, k_d;
  logic [1:0]         c_q, c_d;
  logic [1:0]         ps_q, ps_d;
  logic [SubW-1:0]    j_q, j_d;
  logic [SubW-1:0]    r_q, r_d;
  logic [FRAC_BITS:0] t_q, t_d;
  logic               out_valid_q, out_valid_d;

  logic [SubW-1:0]    subs_q;
  crs_pkg::in_req_t   in_q;
  crs_pkg::out_req_t  out_q;
  logic signed [W-1:0]     win_q [3][3];
  logic signed [W-1:0]     b_q   [3];
  logic signed [W-1:0]     res_q [3];
  logic signed [CoefW-1:0] a3_q  [3];
  logic signed [CoefW-1:0] a2_q  [3];
  logic signed [CoefW-1:0] a1_q  [3];

  logic [SubW-1:0]    cfg_subs;
  logic [SubW-1:0]    subs_eff;
  logic               in_acc;
  logic               out_free;
  logic               emit_fire;
  logic               final_fire;
  logic               shift_win;
  logic               last_j;
  logic               is_tail;
  logic               div_busy;
  logic [FRAC_BITS:0] q0;
  logic [SubW-1:0]    r0;
  logic [SubW:0]      r_sum;
  logic               r_ge;

  logic signed [W-1:0]     cur [3];
  logic signed [W-1:0]     pa [3];
  logic signed [W-1:0]     pb [3];
  logic signed [W-1:0]     pc [3];
  logic signed [W-1:0]     pd [3];
  logic signed [CoefW-1:0] bmc [3];
  logic signed [CoefW-1:0] a3_c [3];
  logic signed [CoefW-1:0] a2_c [3];
  logic signed [CoefW-1:0] a1_c [3];

  crs_pkg::mac_op_t        mac_op;
  logic                    mac_en;
  logic signed [CoefW-1:0] mac_y;

  // Configuration register.
  crs_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .subdivisions_o (cfg_subs)
  );

  // Zero counts as one, large counts saturate.
  always_comb begin
    if (cfg_subs == '0) begin
      subs_eff = SubW'(1);
    end else if (cfg_subs > MaxSub) begin
      subs_eff = MaxSub;
    end else begin
      subs_eff = cfg_subs;
    end
  end

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;
  assign final_fire = (state_q == ST_FINAL) && out_free;
  assign last_j     = (j_q == (subs_q - SubW'(1)));
  assign is_tail    = (segk_q == SEG_TAIL) || (segk_q == SEG_SHORT);

  // Step of the curve parameter: 2^F / S with its remainder.
  crs_recip #(
    .FRAC_BITS (FRAC_BITS)
  ) u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .divisor_i (subs_eff),
    .busy_o    (div_busy),
    .quot_o    (q0),
    .rem_o     (r0)
  );

  // Incremental t = floor(j * 2^F / S): add the quotient, carry the remainder.
  assign r_sum = {1'b0, r_q} + {1'b0, r0};
  assign r_ge  = (r_sum >= {1'b0, subs_q});

  // Point selection for the current segment.
  assign cur[0] = in_q.point_x;
  assign cur[1] = in_q.point_y;
  assign cur[2] = in_q.point_z;

  always_comb begin
    for (int ci = 0; ci < 3; ci++) begin
      case (segk_q)
        SEG_FULL: begin
          pa[ci] = win_q[0][ci];
          pb[ci] = win_q[1][ci];
          pc[ci] = win_q[2][ci];
          pd[ci] = cur[ci];
        end
        SEG_HEAD: begin
          pa[ci] = win_q[1][ci];
          pb[ci] = win_q[1][ci];
          pc[ci] = win_q[2][ci];
          pd[ci] = cur[ci];
        end
        SEG_TAIL: begin
          pa[ci] = win_q[1][ci];
          pb[ci] = win_q[2][ci];
          pc[ci] = cur[ci];
          pd[ci] = cur[ci];
        end
        default: begin
          pa[ci] = win_q[2][ci];
          pb[ci] = win_q[2][ci];
          pc[ci] = cur[ci];
          pd[ci] = cur[ci];
        end
      endcase
    end
  end

  // Cubic coefficients: A3 = -a+3b-3c+d, A2 = 2a-5b+4c-d, A1 = c-a.
  always_comb begin
    for (int ci = 0; ci < 3; ci++) begin
      bmc[ci]  = sext_c(pb[ci]) - sext_c(pc[ci]);
      a3_c[ci] = (sext_c(pd[ci]) - sext_c(pa[ci])) + ((bmc[ci] <<< 1) + bmc[ci]);
      a2_c[ci] = ((sext_c(pa[ci]) <<< 1) - sext_c(pd[ci]))
               + ((sext_c(pc[ci]) <<< 2) - ((sext_c(pb[ci]) <<< 2) + sext_c(pb[ci])));
      a1_c[ci] = sext_c(pc[ci]) - sext_c(pa[ci]);
    end
  end

  // Operand selection for the shared multiply-add unit (Horner steps).
  always_comb begin
    mac_op.half = 1'b0;
    case (k_q)
      K_CUBIC: begin
        mac_op.acc    = a3_q[c_q];
        mac_op.addend = a2_q[c_q];
      end
      K_SQUARE: begin
        mac_op.acc    = mac_y;
        mac_op.addend = a1_q[c_q];
      end
      default: begin
        mac_op.acc    = mac_y;
        mac_op.addend = sext_c(b_q[c_q]);
        mac_op.half   = 1'b1;
      end
    endcase
  end

  assign mac_en = (state_q == ST_MAC) && (k_q != K_STORE);

  crs_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .op_i  (mac_op),
    .t_i   (t_q[FRAC_BITS-1:0]),
    .y_o   (mac_y)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    segk_d    = segk_q;
    k_d       = k_q;
    c_d       = c_q;
    ps_d      = ps_q;
    j_d       = j_q;
    r_d       = r_q;
    t_d       = t_q;
    shift_win = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          if (ps_q == 2'd3) begin
            segk_d  = SEG_FULL;
            state_d = ST_COEF;
          end else if (ps_q == 2'd2) begin
            segk_d  = SEG_HEAD;
            state_d = ST_COEF;
          end else if (in_q.final_point && (ps_q == 2'd1)) begin
            segk_d  = SEG_SHORT;
            state_d = ST_COEF;
          end else if (in_q.final_point) begin
            state_d = ST_FINAL;
          end else begin
            shift_win = 1'b1;
            ps_d      = ps_q + 2'd1;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_COEF: begin
        k_d     = K_CUBIC;
        c_d     = '0;
        j_d     = '0;
        r_d     = '0;
        t_d     = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        if (k_q == K_STORE) begin
          k_d = K_CUBIC;
          if (c_q == 2'd2) begin
            state_d = ST_EMIT;
          end else begin
            c_d = c_q + 2'd1;
          end
        end else begin
          k_d = step_e'(k_q + 2'd1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          k_d = K_CUBIC;
          c_d = '0;
          j_d = j_q + SubW'(1);
          t_d = t_q + q0 + {{FRAC_BITS{1'b0}}, r_ge};
          r_d = r_ge ? SubW'(r_sum - {1'b0, subs_q}) : r_sum[SubW-1:0];
          if (!last_j) begin
            state_d = ST_MAC;
          end else if (in_q.final_point && !is_tail) begin
            segk_d  = SEG_TAIL;
            state_d = ST_COEF;
          end else if (in_q.final_point) begin
            state_d = ST_FINAL;
          end else begin
            shift_win = 1'b1;
            ps_d      = (ps_q == 2'd3) ? ps_q : ps_q + 2'd1;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          ps_d    = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, cleared when the request is taken.
  always_comb begin
    if (emit_fire || final_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      segk_q      <= SEG_FULL;
      k_q         <= K_CUBIC;
      c_q         <= '0;
      ps_q        <= '0;
      j_q         <= '0;
      r_q         <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      segk_q      <= segk_d;
      k_q         <= k_d;
      c_q         <= c_d;
      ps_q        <= ps_d;
      j_q         <= j_d;
      r_q         <= r_d;
      t_q         <= t_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured request, point window, coefficients and results.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q   <= in_req_i;
      subs_q <= subs_eff;
    end
    if (shift_win) begin
      for (int ci = 0; ci < 3; ci++) begin
        win_q[0][ci] <= win_q[1][ci];
        win_q[1][ci] <= win_q[2][ci];
        win_q[2][ci] <= cur[ci];
      end
    end
    if (state_q == ST_COEF) begin
      for (int ci = 0; ci < 3; ci++) begin
        a3_q[ci] <= a3_c[ci];
        a2_q[ci] <= a2_c[ci];
        a1_q[ci] <= a1_c[ci];
        b_q[ci]  <= pb[ci];
      end
    end
    if ((state_q == ST_MAC) && (k_q == K_STORE)) begin
      res_q[c_q] <= mac_y[W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.curve_x  <= res_q[0];
      out_q.curve_y  <= res_q[1];
      out_q.curve_z  <= res_q[2];
      out_q.run_last <= last_j && !in_q.final_point;
      out_q.rope_end <= 1'b0;
    end else if (final_fire) begin
      out_q.curve_x  <= in_q.point_x;
      out_q.curve_y  <= in_q.point_y;
      out_q.curve_z  <= in_q.point_z;
      out_q.run_last <= 1'b1;
      out_q.rope_end <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: hw/rtl/crs_regs.sv
module crs_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crs_pkg::ADDR_W-1:0]   paddr,
  input  logic [crs_pkg::DATA_W-1:0]   pwdata,
  output logic [crs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [crs_pkg::SUB_W-1:0]    subdivisions_o
);

  localparam int unsigned SubW  = crs_pkg::SUB_W;
  localparam int unsigned DataW = crs_pkg::DATA_W;
  localparam int unsigned AddrW = crs_pkg::ADDR_W;

  logic [crs_pkg::IDX_W-1:0] reg_idx;
  logic                      wr_en;
  logic [SubW-1:0]           subs_q;

  // The register index is the word address.
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Subdivision count register; writes to other addresses are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subs_q <= crs_pkg::SUBDIV_RESET;
    end else if (wr_en && (reg_idx == crs_pkg::REG_SUBDIVISIONS)) begin
      subs_q <= pwdata[SubW-1:0];
    end
  end

  // Read back.
  always_comb begin
    if (reg_idx == crs_pkg::REG_SUBDIVISIONS) begin
      prdata = {{(DataW-SubW){1'b0}}, subs_q};
    end else begin
      prdata = '0;
    end
  end

  assign subdivisions_o = subs_q;

endmodule

FILE: hw/rtl/crs_recip.sv
module crs_recip #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [crs_pkg::SUB_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [FRAC_BITS:0]        quot_o,
  output logic [crs_pkg::SUB_W-1:0] rem_o
);

  // Restoring division of 2^FRAC_BITS by the subdivision count, one
  // quotient bit per cycle, most significant bit first.
  localparam int unsigned SubW  = crs_pkg::SUB_W;
  localparam int unsigned CntW  = $clog2(FRAC_BITS + 2);
  localparam logic [CntW-1:0] Steps = CntW'(FRAC_BITS + 1);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [SubW-1:0]   div_q;
  logic [SubW-1:0]   rem_q;
  logic [FRAC_BITS:0] quot_q;

  logic              bit_in;
  logic [SubW:0]     rem_ext;
  logic              ge;
  logic [SubW-1:0]   rem_nx;

  // The dividend is a single one followed by zeros.
  assign bit_in  = (cnt_q == Steps);
  assign rem_ext = {rem_q, bit_in};
  assign ge      = (rem_ext >= {1'b0, div_q});
  assign rem_nx  = ge ? SubW'(rem_ext - {1'b0, div_q}) : rem_ext[SubW-1:0];

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= Steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      quot_q <= {quot_q[FRAC_BITS-1:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/crs_mac.sv
module crs_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  crs_pkg::mac_op_t                 op_i,
  input  logic [FRAC_BITS-1:0]             t_i,
  output logic signed [crs_pkg::COEF_W-1:0] y_o
);

  // y = floor(acc * t / 2^F) + addend, or with one extra halving, registered.
  localparam int unsigned CoefW = crs_pkg::COEF_W;
  localparam int unsigned ProdW = CoefW + FRAC_BITS + 1;

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] shifted;
  logic signed [CoefW-1:0] y_d;
  logic signed [CoefW-1:0] y_q;

  assign prod    = $signed(op_i.acc) * $signed({1'b0, t_i});
  assign shifted = op_i.half ? (prod >>> (FRAC_BITS + 1)) : (prod >>> FRAC_BITS);
  assign y_d     = $signed(shifted[CoefW-1:0]) + $signed(op_i.addend);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule
